// ===== rtl/lifo_stack_with_search_unit_macros.svh =====
// Assertion helpers for the stack unit checker.
// Both sample on clk and are switched off while arst_n is low.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH

// Property that must hold at every edge
`define LSS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define LSS_ASSERT_NEXT(name, cond, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lss_pkg.sv =====
package lss_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Operation codes
	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_SEARCH = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_e_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
		logic [7:0]         depth_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_word;
		logic               found;
		logic [7:0]         position;
		logic [1:0]         status;
		logic               is_empty;
		logic [8:0]         entry_count;
	} rsp_t;

	// Port requests from the sequencer to the word store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [31:0]       wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/lss_mem.sv =====
module lss_mem
	import lss_pkg::*;
(
	input  logic        clk,
	input  mem_req_t    mem_req,
	output logic [31:0] rd_data
);

	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_data_q;

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		rd_data_q <= mem[mem_req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lss_ctrl.sv =====
module lss_ctrl
	import lss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	output mem_req_t    mem_req,
	input  logic [31:0] rd_data
);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [ADDR_W-1:0]   scan_addr_q, scan_addr_d;
	logic [7:0]          pos_q, pos_d;
	logic signed [31:0]  val_q, val_d;
	rsp_t                res_q, res_d;
	rsp_t                out_q, out_d;
	logic                out_valid_q, out_valid_d;
	logic                match;
	logic [ADDR_W-1:0]   top_addr;

	// Shared compare unit: stored word against the search key
	assign match    = (rd_data == val_q);
	assign top_addr = ADDR_W'(fill_q - CNT_W'(1));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Next state, store port and result fields
	always_comb begin
		state_d        = state_q;
		fill_d         = fill_q;
		scan_addr_d    = scan_addr_q;
		pos_d          = pos_q;
		val_d          = val_q;
		res_d          = res_q;
		out_d          = out_q;
		out_valid_d    = out_valid_q && rsp_stall;
		mem_req.we     = 1'b0;
		mem_req.waddr  = ADDR_W'(fill_q);
		mem_req.wdata  = req.value;
		mem_req.raddr  = scan_addr_q - ADDR_W'(1);

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					res_d   = '0;
					state_d = S_DONE;
					case (req.operation)
						OP_PUSH: begin
							if (fill_q == CNT_W'(STACK_DEPTH)) begin
								res_d.status = ST_FULL;
							end else begin
								mem_req.we = 1'b1;
								fill_d     = fill_q + CNT_W'(1);
							end
						end
						OP_POP, OP_PEEK: begin
							if (fill_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								mem_req.raddr = top_addr;
								state_d       = S_READ;
								if (req.operation == OP_POP) begin
									fill_d = fill_q - CNT_W'(1);
								end
							end
						end
						OP_SEARCH: begin
							res_d.status = ST_NOT_FOUND;
							val_d        = req.value;
							if (fill_q != '0) begin
								mem_req.raddr = top_addr;
								scan_addr_d   = top_addr;
								pos_d         = '0;
								state_d       = S_SCAN;
							end
						end
						OP_READ: begin
							if (32'(req.depth_index) < 32'(fill_q)) begin
								mem_req.raddr = ADDR_W'(32'(fill_q) - 32'(req.depth_index)
									- 32'd1);
								state_d       = S_READ;
							end else begin
								res_d.status = ST_NOT_FOUND;
							end
						end
						OP_CLEAR: begin
							fill_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				// Word from the store is ready
				res_d.result_word = rd_data;
				res_d.found       = 1'b1;
				state_d           = S_DONE;
			end
			S_SCAN: begin
				// Compare one word per cycle, walking down from the top
				if (match) begin
					res_d.result_word = val_q;
					res_d.found       = 1'b1;
					res_d.position    = pos_q;
					res_d.status      = ST_OK;
					state_d           = S_DONE;
				end else if (scan_addr_q == '0) begin
					state_d = S_DONE;
				end else begin
					scan_addr_d = scan_addr_q - ADDR_W'(1);
					pos_d       = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
				end
			end
			S_DONE: begin
				// Hand the result over once the output register is free
				if (!out_valid_q || !rsp_stall) begin
					out_d             = res_q;
					out_d.is_empty    = (fill_q == '0);
					out_d.entry_count = 9'(fill_q);
					out_valid_d       = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		scan_addr_q <= scan_addr_d;
		pos_q       <= pos_d;
		val_q       <= val_d;
		res_q       <= res_d;
		out_q       <= out_d;
	end

endmodule

// ===== rtl/lifo_stack_with_search_unit.sv =====
// Bounded LIFO stack of signed 32-bit words with search by value.
// Push, clear and error cases: result goes through the result and output registers.
// Pop, peek, read at depth: a registered store read, then result and output registers.
// Search: one stored word compared per cycle from the top, to a match or the bottom.
// One operation at a time; the next transfer is taken once the result is registered.
// Reset clears the count and the output valid; stored words are not cleared.
module lifo_stack_with_search_unit
	import lss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	mem_req_t    mem_req;
	logic [31:0] rd_data;

	// Sequencer with the shared compare unit
	lss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	// Word store
	lss_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

// ===== rtl/lss_checker.sv =====
`include "lifo_stack_with_search_unit_macros.svh"

module lss_checker
	import lss_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Hold a stalled result
	`LSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(rsp), "stalled result changed")

	// Empty flag follows the count
	`LSS_ASSERT_ALWAYS(a_empty_flag,
		rsp_valid |-> (rsp.is_empty == (rsp.entry_count == 9'd0)),
		"empty flag disagrees with count")

	// No entry means a zero word
	`LSS_ASSERT_ALWAYS(a_zero_word,
		(rsp_valid && !rsp.found) |-> (rsp.result_word == 32'sd0),
		"word set without an entry")

	// A found entry carries good status
	`LSS_ASSERT_ALWAYS(a_found_ok,
		(rsp_valid && rsp.found) |-> (rsp.status == ST_OK),
		"found with error status")

	// Full status only at full count
	`LSS_ASSERT_ALWAYS(a_full_count,
		(rsp_valid && rsp.status == ST_FULL) |-> (rsp.entry_count == 9'(STACK_DEPTH)),
		"full status below capacity")

endmodule

bind lifo_stack_with_search_unit lss_checker u_lss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
